@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the Sv48 translator.
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_SAME(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/sv48_pkg.sv @@
// Types and constants of the Sv48 translator: address layout, fault codes,
// sequencer states. Depends on nothing.
package sv48_pkg;

	localparam int VPN_W = 9;
	localparam int OFF_W = 12;
	localparam int TAG_W = 36;
	localparam int PA_W  = 18;

	typedef enum logic [1:0] {
		FAULT_NONE     = 2'd0,
		FAULT_NONCANON = 2'd1,
		FAULT_NO_PAGE  = 2'd2
	} fault_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_LOOK  = 6'b000100,
		ST_WRD   = 6'b001000,
		ST_WEV   = 6'b010000,
		ST_SPARE = 6'b100000
	} state_t;

endpackage

@@ rtl/sv48_translate_with_tlb.sv @@
// Top level of the Sv48 translator: direct-mapped TLB, table walker, allocator.
// Depends on sv48_pkg and assert_macros.svh.
//
// One address at a time. A TLB hit or a noncanonical address: acceptance reads
// the TLB, the next cycle compares and loads the result once the output register
// is free. A miss walks up to four levels through the single table-store port,
// each level a read, then evaluate and allocate; it ends early with a fault if
// no page is left. After reset a clearing pass writes every table-store entry
// and TLB slot once, one a cycle, with in_ready low meanwhile. A finished result
// waits in the output register while the next address is taken; the walker
// stalls on its final step only if that register is full.
`include "assert_macros.svh"

module sv48_translate_with_tlb
	import sv48_pkg::*;
#(
	parameter int MEM_PAGES   = 64,
	parameter int TLB_ENTRIES = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       virtual_address,
	input  logic              in_valid,
	output logic              in_ready,
	output logic [PA_W-1:0]   physical_address,
	output logic              tlb_hit,
	output logic [1:0]        fault_code,
	output logic              out_valid,
	input  logic              out_ready
);

	localparam int TBL_DEPTH = MEM_PAGES * 512;
	localparam int AW        = $clog2(TBL_DEPTH);
	localparam int PGW       = $clog2(MEM_PAGES);
	localparam int PW        = $clog2(MEM_PAGES + 2);
	localparam int TW        = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int RECIP     = (1 << 18) / TLB_ENTRIES;

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
		logic [PW-1:0]    page;
	} tlb_entry_t;

	logic [PW-1:0]    tbl_mem [0:TBL_DEPTH-1];
	tlb_entry_t       tlb_mem [0:TLB_ENTRIES-1];

	state_t           state_q;
	logic [AW-1:0]    clr_cnt_q;
	logic [PW-1:0]    nfp_q;
	logic [PW-1:0]    page_q;
	logic [1:0]       lvl_q;
	logic [47:0]      va_q;
	logic             noncanon_q;
	logic [TW-1:0]    slot_q;
	tlb_entry_t       tlb_rd_q;
	logic [PW-1:0]    tbl_rd_q;
	logic             out_valid_q;
	logic [PA_W-1:0]  pa_q;
	logic             hit_q;
	fault_t           fault_q;

	logic             accept;
	logic             out_free;
	logic [27:0]      slot_prod;
	logic [9:0]       slot_quo;
	logic [18:0]      slot_back;
	logic [9:0]       slot_rem;
	logic [9:0]       slot_fix;
	logic [TW-1:0]    slot_in;
	logic             tlb_match;
	logic [VPN_W-1:0] walk_idx;
	logic [PW-1:0]    page_m1;
	logic [AW-1:0]    walk_addr;
	logic             e_ok;
	logic             need_alloc;
	logic             exhausted;
	logic             last;
	logic             ev_done;
	logic             proceed;
	logic [PW-1:0]    child;
	logic [PW-1:0]    fin_page;
	logic [PW-1:0]    fin_m1;
	logic [PA_W-1:0]  fin_pa;
	logic             tbl_we;
	logic [AW-1:0]    tbl_wa;
	logic [PW-1:0]    tbl_wd;
	logic             tbl_re;
	logic             tlb_we;
	logic [TW-1:0]    tlb_wa;
	tlb_entry_t       tlb_wd;
	logic             ld_out;
	fault_t           ld_fault;
	logic             ld_hit;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// slot = vpn0 mod TLB_ENTRIES by reciprocal and one correction
	assign slot_prod = 28'(virtual_address[20:12]) * 28'(RECIP);
	assign slot_quo  = slot_prod[27:18];
	assign slot_back = 19'(slot_quo) * 19'(TLB_ENTRIES);
	assign slot_rem  = 10'(virtual_address[20:12]) - slot_back[9:0];
	assign slot_fix  = (slot_rem >= 10'(TLB_ENTRIES)) ? slot_rem - 10'(TLB_ENTRIES) : slot_rem;
	assign slot_in   = slot_fix[TW-1:0];

	assign tlb_match = tlb_rd_q.valid && (tlb_rd_q.tag == va_q[47:12]);

	always_comb begin
		case (lvl_q)
			2'd0: walk_idx = va_q[47:39];
			2'd1: walk_idx = va_q[38:30];
			2'd2: walk_idx = va_q[29:21];
			default: walk_idx = va_q[20:12];
		endcase
	end

	assign page_m1    = page_q - PW'(1);
	assign walk_addr  = {page_m1[PGW-1:0], walk_idx};
	assign e_ok       = (tbl_rd_q != '0) && (tbl_rd_q <= PW'(MEM_PAGES));
	assign need_alloc = !e_ok;
	assign exhausted  = need_alloc && (nfp_q > PW'(MEM_PAGES));
	assign child      = e_ok ? tbl_rd_q : nfp_q;
	assign last       = (lvl_q == 2'd3);
	assign ev_done    = exhausted || last;
	assign proceed    = !ev_done || out_free;

	assign fin_page = (state_q == ST_LOOK) ? tlb_rd_q.page : child;
	assign fin_m1   = fin_page - PW'(1);
	assign fin_pa   = PA_W'({fin_m1, 12'h000}) | PA_W'(va_q[OFF_W-1:0]);

	always_comb begin
		tbl_we   = 1'b0;
		tbl_wa   = walk_addr;
		tbl_wd   = nfp_q;
		tbl_re   = 1'b0;
		tlb_we   = 1'b0;
		tlb_wa   = slot_q;
		tlb_wd   = '{valid: 1'b1, tag: va_q[47:12], page: child};
		ld_out   = 1'b0;
		ld_fault = FAULT_NONE;
		ld_hit   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				tbl_we = 1'b1;
				tbl_wa = clr_cnt_q;
				tbl_wd = '0;
				tlb_we = clr_cnt_q < AW'(TLB_ENTRIES);
				tlb_wa = clr_cnt_q[TW-1:0];
				tlb_wd = '0;
			end
			ST_LOOK: begin
				if (noncanon_q) begin
					ld_out   = out_free;
					ld_fault = FAULT_NONCANON;
				end else if (tlb_match) begin
					ld_out = out_free;
					ld_hit = 1'b1;
				end
			end
			ST_WRD: begin
				tbl_re = 1'b1;
			end
			ST_WEV: begin
				if (proceed) begin
					if (exhausted) begin
						ld_out   = 1'b1;
						ld_fault = FAULT_NO_PAGE;
					end else begin
						tbl_we = need_alloc;
						tlb_we = last;
						ld_out = last;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		if (tbl_re) begin
			tbl_rd_q <= tbl_mem[walk_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (tlb_we) begin
			tlb_mem[tlb_wa] <= tlb_wd;
		end
		if (accept) begin
			tlb_rd_q <= tlb_mem[slot_in];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			va_q       <= virtual_address[47:0];
			noncanon_q <= !((&virtual_address[63:47]) || (~|virtual_address[63:47]));
			slot_q     <= slot_in;
		end
		if (ld_out) begin
			pa_q    <= (ld_fault == FAULT_NONE) ? fin_pa : '0;
			hit_q   <= ld_hit;
			fault_q <= ld_fault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			nfp_q       <= PW'(2);
			page_q      <= PW'(1);
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(TBL_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (noncanon_q || tlb_match) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						page_q  <= PW'(1);
						lvl_q   <= '0;
						state_q <= ST_WRD;
					end
				end
				ST_WRD: begin
					state_q <= ST_WEV;
				end
				ST_WEV: begin
					if (proceed) begin
						if (!exhausted && need_alloc) begin
							nfp_q <= nfp_q + PW'(1);
						end
						if (ev_done) begin
							state_q <= ST_IDLE;
						end else begin
							page_q  <= child;
							lvl_q   <= lvl_q + 2'd1;
							state_q <= ST_WRD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready         = (state_q == ST_IDLE);
	assign out_valid        = out_valid_q;
	assign physical_address = pa_q;
	assign tlb_hit          = hit_q;
	assign fault_code       = fault_q;

	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, accept, !in_ready)
	`ASSERT_SAME(a_hit_no_fault, clk, arst_n, out_valid && tlb_hit, fault_code == FAULT_NONE)
	`ASSERT_SAME(a_fault_zero_pa, clk, arst_n, out_valid && fault_code != FAULT_NONE, physical_address == '0)
	`ASSERT_SAME(a_alloc_bound, clk, arst_n, 1'b1, nfp_q <= PW'(MEM_PAGES + 1))

endmodule
